### hw/rtl/kwsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kwsm_pkg;

  localparam int unsigned DefMaxSources = 8;
  localparam int unsigned DefEntriesPerSource = 256;
  localparam int unsigned IdW = 32;
  localparam int unsigned ScoreW = 16;
  localparam int unsigned EntryW = IdW + ScoreW;
  localparam int unsigned CountW = 4;
  localparam logic [CountW-1:0] CountReset = 4'd2;

  localparam logic [1:0] CmdPush = 2'd0;
  localparam logic [1:0] CmdPop = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StMerged = 3'd1;
  localparam logic [2:0] StWait = 3'd2;
  localparam logic [2:0] StReject = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  typedef enum logic [1:0] {
    OpPush,
    OpPop,
    OpClear,
    OpBad
  } op_e;

  typedef enum logic [2:0] {
    SIdle,
    SRead,
    SCmp,
    SAdv,
    SFin
  } state_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [2:0]        source;
    logic [IdW-1:0]    entry_id;
    logic [ScoreW-1:0] entry_score;
    logic              list_end;
  } in_word_t;

  typedef struct packed {
    logic [IdW-1:0]    out_id;
    logic [ScoreW-1:0] out_score;
    logic [2:0]        status;
    logic              last;
  } out_word_t;

  typedef struct packed {
    op_e      op;
    in_word_t word;
  } cmd_t;

endpackage
`default_nettype wire

### hw/rtl/kwsm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module kwsm_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/kwsm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module kwsm_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire kwsm_pkg::in_word_t in_word_i,
  output logic                    cmd_valid_o,
  input  wire logic               cmd_take_i,
  output kwsm_pkg::cmd_t          cmd_o
);

  kwsm_pkg::cmd_t ent_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       hd_q, hd_d;
  logic       enq;
  kwsm_pkg::op_e op;

  always_comb begin
    unique case (in_word_i.command)
      kwsm_pkg::CmdPush:  op = kwsm_pkg::OpPush;
      kwsm_pkg::CmdPop:   op = kwsm_pkg::OpPop;
      kwsm_pkg::CmdClear: op = kwsm_pkg::OpClear;
      default:            op = kwsm_pkg::OpBad;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign enq         = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = ent_q[hd_q];

  always_comb begin
    cnt_d = cnt_q;
    hd_d  = hd_q;
    if (cmd_take_i) begin
      hd_d = ~hd_q;
    end
    if (enq && !cmd_take_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!enq && cmd_take_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      hd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      hd_q  <= hd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      ent_q[hd_q ^ cnt_q[0]] <= '{op: op, word: in_word_i};
    end
  end

endmodule
`default_nettype wire

### hw/rtl/kwsm_back.sv
`timescale 1ns / 1ps
`default_nettype none
module kwsm_back #(
  parameter int unsigned MAX_SOURCES = kwsm_pkg::DefMaxSources,
  parameter int unsigned ENTRIES_PER_SOURCE = kwsm_pkg::DefEntriesPerSource
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [kwsm_pkg::CountW-1:0]   count_i,
  input  wire logic                          cmd_valid_i,
  output logic                               cmd_take_o,
  input  wire kwsm_pkg::cmd_t                cmd_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output kwsm_pkg::out_word_t                out_word_o
);

  localparam int unsigned Depth = MAX_SOURCES * ENTRIES_PER_SOURCE;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned SW = $clog2(MAX_SOURCES);
  localparam int unsigned PW = $clog2(ENTRIES_PER_SOURCE + 1);
  localparam int unsigned IdW = kwsm_pkg::IdW;
  localparam int unsigned ScW = kwsm_pkg::ScoreW;
  localparam int unsigned CntW = kwsm_pkg::CountW;

  kwsm_pkg::state_e state_q, state_d;
  logic [PW-1:0]  wr_q [MAX_SOURCES];
  logic [PW-1:0]  wr_d [MAX_SOURCES];
  logic [PW-1:0]  rd_q [MAX_SOURCES];
  logic [PW-1:0]  rd_d [MAX_SOURCES];
  logic [MAX_SOURCES-1:0] closed_q, closed_d;
  logic [IdW-1:0] head_q [MAX_SOURCES];
  logic [IdW-1:0] head_d [MAX_SOURCES];
  logic [SW-1:0]  idx_q, idx_d;
  logic [IdW-1:0] min_q, min_d;
  logic [ScW-1:0] best_q, best_d;
  logic           have_q, have_d;
  logic           out_vld_q, out_vld_d;
  kwsm_pkg::out_word_t out_q, out_d;

  logic [kwsm_pkg::CountW-1:0] n_act;
  logic [MAX_SOURCES-1:0] live, starve;
  logic           any_live, any_wait, idx_last, take, load_out, pos_ok;
  logic [SW-1:0]  lane;
  logic           push_ok;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [kwsm_pkg::EntryW-1:0] mem_rdata;
  logic [IdW-1:0] hid;
  logic [ScW-1:0] hsc;

  always_comb begin
    if (count_i == '0) begin
      n_act = CntW'(1);
    end else if (int'(count_i) > int'(MAX_SOURCES)) begin
      n_act = CntW'(MAX_SOURCES);
    end else begin
      n_act = count_i;
    end
  end

  always_comb begin
    pos_ok = 1'b1;
    for (int s = 0; s < int'(MAX_SOURCES); s++) begin
      live[s]   = (s < int'(n_act)) && !(closed_q[s] && (rd_q[s] == wr_q[s]));
      starve[s] = live[s] && (rd_q[s] >= wr_q[s]);
      if (rd_q[s] > wr_q[s]) begin
        pos_ok = 1'b0;
      end
    end
  end

  assign any_live = |live;
  assign any_wait = |starve;
  assign idx_last = (int'(idx_q) + 1 >= int'(n_act));
  assign take     = cmd_valid_i && !out_vld_q && (state_q == kwsm_pkg::SIdle);
  assign cmd_take_o = take;
  assign lane     = SW'(cmd_i.word.source);
  assign push_ok  = (int'(cmd_i.word.source) < int'(n_act)) && !closed_q[lane]
                    && (int'(wr_q[lane]) < int'(ENTRIES_PER_SOURCE));
  assign hid      = mem_rdata[kwsm_pkg::EntryW-1:ScW];
  assign hsc      = mem_rdata[ScW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kwsm_pkg::SIdle: begin
        if (take && cmd_i.op == kwsm_pkg::OpPop && !any_wait && any_live) begin
          state_d = kwsm_pkg::SRead;
        end
      end
      kwsm_pkg::SRead: begin
        if (live[idx_q]) begin
          state_d = kwsm_pkg::SCmp;
        end else if (idx_last) begin
          state_d = kwsm_pkg::SAdv;
        end
      end
      kwsm_pkg::SCmp: begin
        state_d = idx_last ? kwsm_pkg::SAdv : kwsm_pkg::SRead;
      end
      kwsm_pkg::SAdv: state_d = kwsm_pkg::SFin;
      kwsm_pkg::SFin: state_d = kwsm_pkg::SIdle;
      default: state_d = kwsm_pkg::SIdle;
    endcase
  end

  always_comb begin
    wr_d      = wr_q;
    rd_d      = rd_q;
    closed_d  = closed_q;
    head_d    = head_q;
    idx_d     = idx_q;
    min_d     = min_q;
    best_d    = best_q;
    have_d    = have_q;
    out_d     = out_q;
    load_out  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = AW'(int'(lane) * int'(ENTRIES_PER_SOURCE) + int'(wr_q[lane]));
    mem_raddr = AW'(int'(idx_q) * int'(ENTRIES_PER_SOURCE) + int'(rd_q[idx_q]));
    unique case (state_q)
      kwsm_pkg::SIdle: begin
        idx_d  = '0;
        have_d = 1'b0;
        best_d = '0;
        min_d  = '0;
        if (take) begin
          load_out = 1'b1;
          out_d    = '{out_id: '0, out_score: '0, status: kwsm_pkg::StReject, last: 1'b0};
          case (cmd_i.op)
            kwsm_pkg::OpPush: begin
              if (push_ok) begin
                mem_we       = 1'b1;
                wr_d[lane]   = wr_q[lane] + PW'(1);
                closed_d[lane] = closed_q[lane] | cmd_i.word.list_end;
                out_d.status = kwsm_pkg::StOk;
              end
            end
            kwsm_pkg::OpClear: begin
              for (int s = 0; s < int'(MAX_SOURCES); s++) begin
                wr_d[s] = '0;
                rd_d[s] = '0;
              end
              closed_d     = '0;
              out_d.status = kwsm_pkg::StOk;
            end
            kwsm_pkg::OpPop: begin
              if (any_wait) begin
                out_d.status = kwsm_pkg::StWait;
              end else if (!any_live) begin
                out_d.status = kwsm_pkg::StDone;
              end else begin
                load_out = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      kwsm_pkg::SRead: begin
        if (live[idx_q]) begin
          mem_re = 1'b1;
        end else if (!idx_last) begin
          idx_d = idx_q + SW'(1);
        end
      end
      kwsm_pkg::SCmp: begin
        head_d[idx_q] = hid;
        if (!have_q || hid < min_q) begin
          min_d  = hid;
          best_d = hsc;
          have_d = 1'b1;
        end else if (hid == min_q && hsc > best_q) begin
          best_d = hsc;
        end
        if (!idx_last) begin
          idx_d = idx_q + SW'(1);
        end
      end
      kwsm_pkg::SAdv: begin
        for (int s = 0; s < int'(MAX_SOURCES); s++) begin
          if (live[s] && head_q[s] == min_q) begin
            rd_d[s] = rd_q[s] + PW'(1);
          end
        end
      end
      kwsm_pkg::SFin: begin
        load_out = 1'b1;
        out_d    = '{out_id: min_q, out_score: best_q, status: kwsm_pkg::StMerged,
                     last: !any_live};
      end
      default: ;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (load_out) begin
      out_vld_d = 1'b1;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= kwsm_pkg::SIdle;
      closed_q  <= '0;
      out_vld_q <= 1'b0;
      for (int s = 0; s < int'(MAX_SOURCES); s++) begin
        wr_q[s] <= '0;
        rd_q[s] <= '0;
      end
    end else begin
      state_q   <= state_d;
      closed_q  <= closed_d;
      out_vld_q <= out_vld_d;
      wr_q      <= wr_d;
      rd_q      <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    idx_q  <= idx_d;
    min_q  <= min_d;
    best_q <= best_d;
    have_q <= have_d;
    out_q  <= out_d;
  end

  kwsm_ram #(
    .WIDTH(kwsm_pkg::EntryW),
    .DEPTH(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i({cmd_i.word.entry_id, cmd_i.word.entry_score}),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  a_pos_order: assert property (@(posedge clk_i) disable iff (!rst_ni) pos_ok)
    else $error("read position passed write position");
  a_adv_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kwsm_pkg::SAdv) |-> have_q)
    else $error("advance without a minimum");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !out_vld_q)
    else $error("result loaded over a pending word");
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (take && cmd_i.op == kwsm_pkg::OpPush))
    else $error("store written outside a push");
  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kwsm_pkg::SFin) |=> (out_vld_q && out_q.status == kwsm_pkg::StMerged))
    else $error("merged word not presented");

endmodule
`default_nettype wire

### hw/rtl/kway_sorted_merge_max_combine_unit.sv
// Push, clear, rejected, waiting, finished words: front queue register, then output word.
// Merging pop: states read (per list), compare (live lists), advance, finish.
// Throughput: the back end takes the next word only once the pending output word is taken;
// the front queue holds up to two words meanwhile.
// Reset: asynchronous active low; clears positions, closed flags, queue, source_count = 2.
// Store contents are not cleared; only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none
module kway_sorted_merge_max_combine_unit #(
  parameter int unsigned MAX_SOURCES = kwsm_pkg::DefMaxSources,
  parameter int unsigned ENTRIES_PER_SOURCE = kwsm_pkg::DefEntriesPerSource
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire kwsm_pkg::in_word_t          in_word_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output kwsm_pkg::out_word_t              out_word_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [kwsm_pkg::CountW-1:0] cfg_data_i
);

  logic [kwsm_pkg::CountW-1:0] count_q;
  logic           cmd_valid, cmd_take;
  kwsm_pkg::cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= kwsm_pkg::CountReset;
    end else if (cfg_we_i) begin
      count_q <= cfg_data_i;
    end
  end

  kwsm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .cmd_valid_o(cmd_valid),
    .cmd_take_i (cmd_take),
    .cmd_o      (cmd)
  );

  kwsm_back #(
    .MAX_SOURCES       (MAX_SOURCES),
    .ENTRIES_PER_SOURCE(ENTRIES_PER_SOURCE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .count_i    (count_q),
    .cmd_valid_i(cmd_valid),
    .cmd_take_o (cmd_take),
    .cmd_i      (cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

endmodule
`default_nettype wire

### verif/kwsm_checker.sv
`timescale 1ns / 1ps
module kwsm_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  kwsm_pkg::in_word_t          in_word_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  kwsm_pkg::out_word_t         out_word_i,
  input  logic                        cfg_we_i,
  input  logic [kwsm_pkg::CountW-1:0] cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          merged_count_o
);

  localparam int Lists = kwsm_pkg::DefMaxSources;
  localparam int Depth = kwsm_pkg::DefEntriesPerSource;
  localparam int EW = kwsm_pkg::EntryW;
  localparam int SW = kwsm_pkg::ScoreW;

  logic [EW-1:0] list_mem [Lists][Depth];
  int unsigned wr_pos [Lists];
  int unsigned rd_pos [Lists];
  bit closed [Lists];
  logic [kwsm_pkg::CountW-1:0] count_reg;
  kwsm_pkg::out_word_t merged_q [$];

  function automatic bit drained(int s);
    return closed[s] && rd_pos[s] == wr_pos[s];
  endfunction

  function automatic kwsm_pkg::out_word_t merge_word(kwsm_pkg::in_word_t w);
    kwsm_pkg::out_word_t r;
    int n;
    bit live;
    bit have;
    logic [kwsm_pkg::IdW-1:0] low_id;
    logic [SW-1:0] top;
    logic [EW-1:0] e;
    r = '0;
    n = (count_reg == 0) ? 1 : (count_reg > Lists) ? Lists : count_reg;
    if (w.command == kwsm_pkg::CmdPush) begin
      if (w.source >= n || closed[w.source] || wr_pos[w.source] >= Depth) begin
        r.status = kwsm_pkg::StReject;
      end else begin
        list_mem[w.source][wr_pos[w.source]] = {w.entry_id, w.entry_score};
        wr_pos[w.source]++;
        if (w.list_end) closed[w.source] = 1;
        r.status = kwsm_pkg::StOk;
      end
      return r;
    end
    if (w.command == kwsm_pkg::CmdClear) begin
      for (int s = 0; s < Lists; s++) begin
        wr_pos[s] = 0;
        rd_pos[s] = 0;
        closed[s] = 0;
      end
      r.status = kwsm_pkg::StOk;
      return r;
    end
    if (w.command != kwsm_pkg::CmdPop) begin
      r.status = kwsm_pkg::StReject;
      return r;
    end
    live = 0;
    for (int s = 0; s < n; s++) begin
      if (drained(s)) continue;
      if (rd_pos[s] >= wr_pos[s]) begin
        r.status = kwsm_pkg::StWait;
        return r;
      end
      live = 1;
    end
    if (!live) begin
      r.status = kwsm_pkg::StDone;
      return r;
    end
    have = 0;
    low_id = '0;
    top = '0;
    for (int s = 0; s < n; s++) begin
      if (drained(s)) continue;
      e = list_mem[s][rd_pos[s]];
      if (!have || e[EW-1:SW] < low_id) begin
        low_id = e[EW-1:SW];
        have = 1;
      end
    end
    for (int s = 0; s < n; s++) begin
      if (drained(s)) continue;
      e = list_mem[s][rd_pos[s]];
      if (e[EW-1:SW] == low_id) begin
        if (e[SW-1:0] > top) top = e[SW-1:0];
        rd_pos[s]++;
      end
    end
    r.last = 1;
    for (int s = 0; s < n; s++) if (!drained(s)) r.last = 0;
    r.out_id = low_id;
    r.out_score = top;
    r.status = kwsm_pkg::StMerged;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    kwsm_pkg::out_word_t exp_w;
    if (!rst_ni) begin
      for (int s = 0; s < Lists; s++) begin
        wr_pos[s] = 0;
        rd_pos[s] = 0;
        closed[s] = 0;
      end
      count_reg = kwsm_pkg::CountReset;
      merged_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
      merged_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (merged_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_word_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_w = merged_q.pop_front();
          if (exp_w !== out_word_i) begin
            $display("%0t: expected id %h score %h st %0d last %0d, got id %h score %h st %0d last %0d",
                     $time, exp_w.out_id, exp_w.out_score, exp_w.status, exp_w.last,
                     out_word_i.out_id, out_word_i.out_score, out_word_i.status,
                     out_word_i.last);
            fail_count_o <= fail_count_o + 1;
          end
          if (exp_w.status == kwsm_pkg::StMerged) merged_count_o <= merged_count_o + 1;
        end
      end
      if (in_valid_i && in_ready_i) merged_q.push_back(merge_word(in_word_i));
      if (cfg_we_i) count_reg = cfg_data_i;
      pending_o <= merged_q.size();
    end
  end
endmodule

### verif/tb.sv
`timescale 1ns / 1ps
module tb;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  kwsm_pkg::in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  kwsm_pkg::out_word_t out_word_o;
  logic cfg_we_i = 0;
  logic [kwsm_pkg::CountW-1:0] cfg_data_i = '0;
  int fail_count, pending, merged_count;
  int idle_pct = 0, stall_pct = 0;
  int quiet_cycles = 0;
  int sent = 0;
  int fill_pos [8];
  logic [31:0] next_id [8];

  always #4 clk_i = ~clk_i;

  kway_sorted_merge_max_combine_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_word_o(out_word_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  kwsm_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_i(in_ready_o), .in_word_i(in_word_i),
    .out_valid_i(out_valid_o), .out_ready_i(out_ready_i), .out_word_i(out_word_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .fail_count_o(fail_count), .pending_o(pending), .merged_count_o(merged_count)
  );

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_word(logic [1:0] cmd, logic [2:0] src, logic [31:0] id,
                           logic [15:0] score, logic fin);
    kwsm_pkg::in_word_t w;
    bit gap;
    w.command = cmd;
    w.source = src;
    w.entry_id = id;
    w.entry_score = score;
    w.list_end = fin;
    gap = ($urandom_range(99) < idle_pct);
    if (gap) in_valid_i <= 0;
    while (gap) begin
      @(posedge clk_i);
      gap = ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1;
    in_word_i <= w;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    sent++;
  endtask

  task automatic settle();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_count(logic [3:0] v);
    settle();
    cfg_we_i <= 1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  // fill lists with non-decreasing ids, interleaved with pops and noise
  task automatic merge_round(int lists, int len);
    int r;
    int s;
    for (s = 0; s < 8; s++) begin
      fill_pos[s] = 0;
      next_id[s] = $urandom_range(20);
    end
    send_word(kwsm_pkg::CmdClear, 0, 0, 0, 0);
    for (int k = 0; k < lists * len + len; k++) begin
      r = $urandom_range(99);
      s = $urandom_range(lists - 1);
      if (r < 55 && fill_pos[s] < len) begin
        next_id[s] = next_id[s] + $urandom_range(3);
        send_word(kwsm_pkg::CmdPush, s, next_id[s], $urandom, fill_pos[s] == len - 1);
        fill_pos[s]++;
      end else if (r < 92) begin
        send_word(kwsm_pkg::CmdPop, $urandom, $urandom, $urandom, $urandom);
      end else if (r < 97) begin
        send_word(kwsm_pkg::CmdPush, $urandom, $urandom, $urandom, $urandom);
      end else begin
        send_word(kwsm_pkg::OpBad, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_word(kwsm_pkg::CmdPop, 0, 0, 0, 0);
    send_word(kwsm_pkg::CmdPush, 0, 32'hFFFF_FFFE, 16'hFFFF, 0);
    send_word(kwsm_pkg::CmdPush, 1, 32'h0, 16'h0, 1);
    send_word(kwsm_pkg::CmdPush, 2, 5, 5, 0);
    send_word(kwsm_pkg::CmdPop, 0, 0, 0, 0);
    send_word(kwsm_pkg::CmdPush, 1, 9, 9, 0);
    send_word(kwsm_pkg::CmdPush, 0, 32'hFFFF_FFFE, 16'h1, 1);
    send_word(kwsm_pkg::CmdPop, 0, 0, 0, 0);
    send_word(kwsm_pkg::CmdPop, 0, 0, 0, 0);
    send_word(kwsm_pkg::CmdPop, 0, 0, 0, 0);
    send_word(kwsm_pkg::OpBad, 7, 32'hFFFF_FFFF, 16'hFFFF, 1);
    send_word(kwsm_pkg::CmdClear, 0, 0, 0, 0);
    set_count(0);
    send_word(kwsm_pkg::CmdPush, 1, 3, 3, 0);
    send_word(kwsm_pkg::CmdPush, 0, 3, 3, 1);
    send_word(kwsm_pkg::CmdPop, 0, 0, 0, 0);
    send_word(kwsm_pkg::CmdPop, 0, 0, 0, 0);
    set_count(15);
    send_word(kwsm_pkg::CmdClear, 0, 0, 0, 0);
    for (int s = 0; s < 8; s++) send_word(kwsm_pkg::CmdPush, s, 7, s * 1000, 1);
    send_word(kwsm_pkg::CmdPop, 0, 0, 0, 0);
    send_word(kwsm_pkg::CmdPop, 0, 0, 0, 0);
    set_count(2);
    send_word(kwsm_pkg::CmdClear, 0, 0, 0, 0);
    for (int k = 0; k < 257; k++) send_word(kwsm_pkg::CmdPush, 0, k, k, 0);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? 75 : 0;
      stall_pct = (ph == 2 || ph == 3) ? 75 : 0;
      if (ph == 3) begin
        idle_pct = 9;
        stall_pct = 9;
      end
      for (int c = 0; c < 8; c++) begin
        set_count(c == 0 ? 8 : c == 1 ? 1 : $urandom_range(15));
        merge_round(c == 1 ? 1 : $urandom_range(1, 8), $urandom_range(3, 8));
      end
    end
    idle_pct = 0;
    stall_pct = 0;
    settle();
    $display("sent %0d words, %0d merged entries, counts 0..15 incl. extremes", sent,
             merged_count);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
